/* rtl/http_response_chunk_decoder_unit_macros.svh */
// Assertion macros for the chunk decoder.
`ifndef HTTP_RESPONSE_CHUNK_DECODER_UNIT_MACROS_SVH
`define HTTP_RESPONSE_CHUNK_DECODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every edge outside reset.
`define HRCD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("hrcd assertion failed");
// Condition in one cycle that forces a condition in the next.
`define HRCD_ASSERT_NEXT(label, clk, rst, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
    else $error("hrcd assertion failed");
`else
`define HRCD_ASSERT(label, clk, rst, prop)
`define HRCD_ASSERT_NEXT(label, clk, rst, cond, nxt)
`endif

`endif

/* rtl/hrcd_pkg.sv */
package hrcd_pkg;

  localparam int CHUNK_SIZE_BITS_DEFAULT = 32;

  // header pattern, matched case-insensitively
  localparam int PAT_LEN = 26;
  localparam logic [PAT_LEN*8-1:0] TE_PATTERN = "transfer-encoding: chunked";

  localparam int STATUS_MAX = 999;
  localparam logic [1:0] SKIP_BYTES = 2'd2;

  // result queue
  localparam int RESULT_FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(RESULT_FIFO_DEPTH);
  localparam int FIFO_LEVEL_W = $clog2(RESULT_FIFO_DEPTH + 1);

  // characters of interest
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_VT   = 8'h0b;
  localparam logic [7:0] CH_FF   = 8'h0c;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_LC_T = 8'h74;

  typedef enum logic [2:0] {
    PH_STATUS,
    PH_HEADER,
    PH_PLAIN,
    PH_CSIZE,
    PH_CEXT,
    PH_CDATA,
    PH_CSKIP,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    SUB_BEFORE,
    SUB_WS,
    SUB_DIGITS,
    SUB_END
  } status_sub_t;

  typedef enum logic {
    KIND_BODY    = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] body_byte;
    logic [9:0] status_code;
    logic       response_ok;
    logic       was_chunked;
    logic       truncated;
    logic       last;
  } result_t;

  // up to two results per item, written in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_push_t;

  function automatic logic [7:0] te_char(logic [4:0] idx);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < PAT_LEN; i++) begin
      if (idx == 5'(i)) c = TE_PATTERN[8*(PAT_LEN-1-i) +: 8];
    end
    return c;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic is_hex(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic [3:0] hex_value(logic [7:0] b);
    logic [7:0] v;
    if (b >= "0" && b <= "9") v = b - "0";
    else if (b >= "a" && b <= "f") v = b - "a" + 8'd10;
    else v = b - "A" + 8'd10;
    return v[3:0];
  endfunction

endpackage

/* rtl/hrcd_ifs.sv */
// Input channel: at most one raw response byte per item.
interface hrcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       stream_end;

  modport source (output valid, data_byte, byte_valid, stream_end, input ready);
  modport sink (input valid, data_byte, byte_valid, stream_end, output ready);
endinterface

// Output channel: decoded body byte or end-of-response summary.
interface hrcd_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] body_byte;
  logic [9:0] status_code;
  logic       response_ok;
  logic       was_chunked;
  logic       truncated;
  logic       last;

  modport source (output valid, result_kind, body_byte, status_code, response_ok,
                  was_chunked, truncated, last, input ready);
  modport sink (input valid, result_kind, body_byte, status_code, response_ok,
                was_chunked, truncated, last, output ready);
endinterface

/* rtl/hrcd_parser.sv */
module hrcd_parser
  import hrcd_pkg::*;
#(
  parameter int CHUNK_SIZE_BITS = CHUNK_SIZE_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  logic [7:0]   data_byte,
  input  logic         byte_valid,
  input  logic         stream_end,
  output result_push_t push
);

  localparam logic [CHUNK_SIZE_BITS-1:0] SIZE_MAX = '1;

  phase_t                     phase, phase_next;
  status_sub_t                sub, sub_next;
  logic [1:0]                 term, term_next;
  logic [4:0]                 pat, pat_next;
  logic [9:0]                 status_value, status_next;
  logic                       chunked_seen, chunked_next;
  logic [CHUNK_SIZE_BITS-1:0] chunk_rem, chunk_rem_next;
  logic [1:0]                 skip_count, skip_next;
  logic                       summary_sent, summary_next;

  logic        live;
  logic        emit;
  logic        finish;
  logic [7:0]  lower;
  logic        is_ws;
  logic        is_dig;
  logic [13:0] status_mul;
  result_t     body_res, sum_res;

  assign live   = take && !summary_sent;
  assign lower  = to_lower(data_byte);
  assign is_dig = data_byte >= "0" && data_byte <= "9";
  assign is_ws  = data_byte == CH_SP || data_byte == CH_TAB || data_byte == CH_LF ||
                  data_byte == CH_VT || data_byte == CH_FF || data_byte == CH_CR;
  // value*10 + digit, wide enough that saturation is a plain compare
  assign status_mul = {1'b0, status_value, 3'b000} + {3'b000, status_value, 1'b0} +
                      {10'd0, data_byte[3:0]};

  // per-byte state update
  always_comb begin
    phase_next     = phase;
    sub_next       = sub;
    term_next      = term;
    pat_next       = pat;
    status_next    = status_value;
    chunked_next   = chunked_seen;
    chunk_rem_next = chunk_rem;
    skip_next      = skip_count;
    emit           = 1'b0;
    if (live && byte_valid) begin
      unique case (phase)
        PH_STATUS, PH_HEADER: begin
          // header pattern search
          if (lower == te_char(pat)) begin
            if (pat == 5'(PAT_LEN - 1)) begin
              chunked_next = 1'b1;
              pat_next     = '0;
            end else begin
              pat_next = pat + 5'd1;
            end
          end else begin
            pat_next = (lower == CH_LC_T) ? 5'd1 : 5'd0;
          end
          // blank line ends the header
          if (data_byte == CH_LF && term == 2'd3) begin
            term_next = '0;
            if (sub == SUB_BEFORE) begin
              phase_next = PH_DONE;
            end else if (chunked_next) begin
              phase_next     = PH_CSIZE;
              chunk_rem_next = '0;
            end else begin
              phase_next = PH_PLAIN;
            end
          end else begin
            if (data_byte == CH_CR) term_next = (term == 2'd2) ? 2'd3 : 2'd1;
            else if (data_byte == CH_LF && term == 2'd1) term_next = 2'd2;
            else term_next = 2'd0;
            // status line parsing
            if (phase == PH_STATUS) begin
              if (data_byte == CH_LF && term == 2'd1) begin
                phase_next = PH_HEADER;
                if (sub != SUB_BEFORE) sub_next = SUB_END;
              end else begin
                unique case (sub)
                  SUB_BEFORE: if (data_byte == CH_SP) sub_next = SUB_WS;
                  SUB_WS: begin
                    if (!is_ws) begin
                      if (data_byte == CH_PLUS) begin
                        sub_next = SUB_DIGITS;
                      end else if (is_dig) begin
                        status_next = {6'd0, data_byte[3:0]};
                        sub_next    = SUB_DIGITS;
                      end else begin
                        status_next = '0;
                        sub_next    = SUB_END;
                      end
                    end
                  end
                  SUB_DIGITS: begin
                    if (is_dig) begin
                      status_next = (status_mul > 14'(STATUS_MAX)) ? 10'(STATUS_MAX)
                                                                   : status_mul[9:0];
                    end else begin
                      sub_next = SUB_END;
                    end
                  end
                  SUB_END: ;
                endcase
              end
            end
          end
        end
        PH_PLAIN: emit = 1'b1;
        PH_CSIZE: begin
          if (is_hex(data_byte)) begin
            if (chunk_rem > (SIZE_MAX >> 4)) chunk_rem_next = SIZE_MAX;
            else chunk_rem_next = {chunk_rem[CHUNK_SIZE_BITS-5:0], hex_value(data_byte)};
          end else begin
            phase_next = PH_CEXT;
            term_next  = (data_byte == CH_CR) ? 2'd1 : 2'd0;
          end
        end
        PH_CEXT: begin
          if (data_byte == CH_LF && term == 2'd1) begin
            term_next  = '0;
            phase_next = (chunk_rem == '0) ? PH_DONE : PH_CDATA;
          end else begin
            term_next = (data_byte == CH_CR) ? 2'd1 : 2'd0;
          end
        end
        PH_CDATA: begin
          emit           = 1'b1;
          chunk_rem_next = chunk_rem - 1'b1;
          if (chunk_rem_next == '0) begin
            phase_next = PH_CSKIP;
            skip_next  = SKIP_BYTES;
          end
        end
        PH_CSKIP: begin
          if (skip_count != '0) skip_next = skip_count - 2'd1;
          if (skip_next == '0) begin
            phase_next     = PH_CSIZE;
            chunk_rem_next = '0;
            term_next      = '0;
          end
        end
        PH_DONE: ;
      endcase
    end
  end

  assign finish       = live && stream_end;
  assign summary_next = summary_sent || finish;

  // results of this item
  always_comb begin
    body_res             = '0;
    body_res.result_kind = KIND_BODY;
    body_res.body_byte   = data_byte;

    sum_res             = '0;
    sum_res.result_kind = KIND_SUMMARY;
    sum_res.status_code = status_next;
    sum_res.response_ok = phase_next != PH_STATUS && phase_next != PH_HEADER &&
                          sub_next != SUB_BEFORE;
    sum_res.was_chunked = chunked_next;
    sum_res.truncated   = phase_next == PH_CDATA && chunk_rem_next != '0;
    sum_res.last        = 1'b1;

    push.count  = {1'b0, emit} + {1'b0, finish};
    push.first  = emit ? body_res : sum_res;
    push.second = sum_res;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_STATUS;
      sub          <= SUB_BEFORE;
      term         <= '0;
      pat          <= '0;
      status_value <= '0;
      chunked_seen <= 1'b0;
      chunk_rem    <= '0;
      skip_count   <= '0;
      summary_sent <= 1'b0;
    end else begin
      phase        <= phase_next;
      sub          <= sub_next;
      term         <= term_next;
      pat          <= pat_next;
      status_value <= status_next;
      chunked_seen <= chunked_next;
      chunk_rem    <= chunk_rem_next;
      skip_count   <= skip_next;
      summary_sent <= summary_next;
    end
  end

endmodule

/* rtl/hrcd_result_fifo.sv */
module hrcd_result_fifo
  import hrcd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  result_push_t            push,
  input  logic                    pop,
  output result_t                 head,
  output logic                    head_valid,
  output logic [FIFO_LEVEL_W-1:0] level
);

  result_t                 entries [RESULT_FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_PTR_W-1:0]   wr_ptr_1;

  assign wr_ptr_1   = wr_ptr + 1'b1;
  assign head       = entries[rd_ptr];
  assign head_valid = level != '0;

  // storage; the second result of an item goes one slot behind the first
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.first;
    if (push.count == 2'd2) entries[wr_ptr_1] <= push.second;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      level <= level + FIFO_LEVEL_W'(push.count) - FIFO_LEVEL_W'(pop);
    end
  end

endmodule

/* rtl/http_response_chunk_decoder_unit.sv */
// HTTP/1.1 response decoder. One raw byte item is taken per clock. The first result
// an item causes (a body byte, or the summary when no byte goes out) is written into
// the result queue on acceptance. When the stream_end item also passes a body byte,
// its summary follows in the cycle after that byte leaves. Results wait in a four-entry
// queue, so input is taken while the queue has room for two more results; with the
// output always ready the block sustains one item per cycle. The item carrying
// stream_end is the last one that produces results until the next reset.
`include "http_response_chunk_decoder_unit_macros.svh"

module http_response_chunk_decoder_unit
  import hrcd_pkg::*;
#(
  parameter int CHUNK_SIZE_BITS = CHUNK_SIZE_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  hrcd_in_if.sink    byte_ch,
  hrcd_out_if.source result_ch
);

  result_push_t            push;
  result_t                 head;
  logic                    head_valid;
  logic [FIFO_LEVEL_W-1:0] level;
  logic                    take;
  logic                    pop;

  // room for the two results one item can cause
  assign byte_ch.ready = level <= FIFO_LEVEL_W'(RESULT_FIFO_DEPTH - 2);
  assign take          = byte_ch.valid && byte_ch.ready;
  assign pop           = result_ch.valid && result_ch.ready;

  hrcd_parser #(
    .CHUNK_SIZE_BITS (CHUNK_SIZE_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (byte_ch.data_byte),
    .byte_valid (byte_ch.byte_valid),
    .stream_end (byte_ch.stream_end),
    .push       (push)
  );

  hrcd_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .level      (level)
  );

  // output channel
  assign result_ch.valid       = head_valid;
  assign result_ch.result_kind = head.result_kind;
  assign result_ch.body_byte   = head.body_byte;
  assign result_ch.status_code = head.status_code;
  assign result_ch.response_ok = head.response_ok;
  assign result_ch.was_chunked = head.was_chunked;
  assign result_ch.truncated   = head.truncated;
  assign result_ch.last        = head.last;

  // checks
  `HRCD_ASSERT(a_level_bound, clk, rst, level <= FIFO_LEVEL_W'(RESULT_FIFO_DEPTH))
  `HRCD_ASSERT(a_push_only_on_take, clk, rst, !take |-> push.count == 2'd0)
  `HRCD_ASSERT(a_summary_marks_last, clk, rst, result_ch.valid |-> (result_ch.result_kind == result_ch.last))
  `HRCD_ASSERT_NEXT(a_nothing_after_last, clk, rst, pop && result_ch.last, !result_ch.valid)

endmodule

/* tb/sv/hrcd_result_checker.sv */
// Watches both channels of the chunk decoder, predicts the results of every
// accepted byte item and compares them, in order, with what the block emits.
module hrcd_result_checker
  import hrcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  hrcd_in_if          byte_ch,
  hrcd_out_if         result_ch,
  output int unsigned mismatches,
  output int unsigned awaited_count
);

  localparam int SIZE_W = CHUNK_SIZE_BITS_DEFAULT;
  localparam logic [SIZE_W-1:0] SIZE_SAT = '1;
  localparam int MAX_REPORTS = 10;

  // decoder state as the checker sees it
  phase_t            phase;
  status_sub_t       status_sub;
  logic [1:0]        term_cnt;
  logic [4:0]        te_match;
  logic [9:0]        status_val;
  logic              chunked;
  logic [SIZE_W-1:0] chunk_left;
  logic              size_digit;
  logic [1:0]        skip_left;
  logic              closed;

  result_t awaited_results[$];

  function automatic void clear_decoder();
    phase      = PH_STATUS;
    status_sub = SUB_BEFORE;
    term_cnt   = '0;
    te_match   = '0;
    status_val = '0;
    chunked    = 1'b0;
    chunk_left = '0;
    size_digit = 1'b0;
    skip_left  = '0;
    closed     = 1'b0;
  endfunction

  function automatic logic [7:0] te_pattern_at(logic [4:0] idx);
    return TE_PATTERN[8*(PAT_LEN-1-int'(idx)) +: 8];
  endfunction

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(logic [7:0] b);
    if (b >= "0" && b <= "9") return {1'b1, 4'(b - "0")};
    if (b >= "a" && b <= "f") return {1'b1, 4'(b - "a" + 8'd10)};
    if (b >= "A" && b <= "F") return {1'b1, 4'(b - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic void open_size_line();
    phase      = PH_CSIZE;
    chunk_left = '0;
    size_digit = 1'b0;
    term_cnt   = '0;
  endfunction

  // status text after the first space: whitespace, optional '+', digits
  function automatic void take_status_char(logic [7:0] b);
    logic ws;
    logic dig;
    int   v;
    ws  = b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_VT || b == CH_FF || b == CH_CR;
    dig = b >= "0" && b <= "9";
    case (status_sub)
      SUB_BEFORE: begin
        if (b == CH_SP) status_sub = SUB_WS;
      end
      SUB_WS: begin
        if (!ws) begin
          if (b == CH_PLUS) begin
            status_sub = SUB_DIGITS;
          end else if (dig) begin
            status_val = 10'(b - "0");
            status_sub = SUB_DIGITS;
          end else begin
            status_val = '0;
            status_sub = SUB_END;
          end
        end
      end
      SUB_DIGITS: begin
        if (dig) begin
          v = int'(status_val) * 10 + int'(b - "0");
          status_val = (v > STATUS_MAX) ? 10'(STATUS_MAX) : 10'(v);
        end else begin
          status_sub = SUB_END;
        end
      end
      default: ;
    endcase
  endfunction

  // header bytes: pattern search, blank-line search, status line
  function automatic void take_header_byte(logic [7:0] b);
    logic [7:0] lower;
    logic [1:0] prev;
    lower = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    prev  = term_cnt;

    if (lower == te_pattern_at(te_match)) begin
      te_match = te_match + 5'd1;
      if (te_match == 5'(PAT_LEN)) begin
        chunked  = 1'b1;
        te_match = '0;
      end
    end else begin
      te_match = (lower == CH_LC_T) ? 5'd1 : 5'd0;
    end

    if (b == CH_LF && prev == 2'd3) begin
      if (status_sub == SUB_BEFORE) begin
        phase    = PH_DONE;
        term_cnt = '0;
      end else if (chunked) begin
        open_size_line();
      end else begin
        phase    = PH_PLAIN;
        term_cnt = '0;
      end
      return;
    end
    if (b == CH_CR) term_cnt = (prev == 2'd2) ? 2'd3 : 2'd1;
    else if (b == CH_LF && prev == 2'd1) term_cnt = 2'd2;
    else term_cnt = 2'd0;

    if (phase == PH_STATUS) begin
      if (b == CH_LF && prev == 2'd1) begin
        phase = PH_HEADER;
        if (status_sub != SUB_BEFORE) status_sub = SUB_END;
      end else begin
        take_status_char(b);
      end
    end
  endfunction

  // one raw byte; returns 1 when it goes out as a body byte
  function automatic logic take_byte(logic [7:0] b);
    logic       emit;
    logic [4:0] h;
    emit = 1'b0;
    case (phase)
      PH_STATUS, PH_HEADER: take_header_byte(b);
      PH_PLAIN: emit = 1'b1;
      PH_CSIZE: begin
        h = hex_digit(b);
        if (h[4]) begin
          size_digit = 1'b1;
          if (chunk_left > (SIZE_SAT >> 4)) chunk_left = SIZE_SAT;
          else chunk_left = {chunk_left[SIZE_W-5:0], h[3:0]};
        end else begin
          phase    = PH_CEXT;
          term_cnt = (b == CH_CR) ? 2'd1 : 2'd0;
        end
      end
      PH_CEXT: begin
        if (b == CH_LF && term_cnt == 2'd1) begin
          term_cnt = '0;
          phase    = (chunk_left == '0) ? PH_DONE : PH_CDATA;
        end else begin
          term_cnt = (b == CH_CR) ? 2'd1 : 2'd0;
        end
      end
      PH_CDATA: begin
        chunk_left = chunk_left - 1'b1;
        if (chunk_left == '0) begin
          phase     = PH_CSKIP;
          skip_left = SKIP_BYTES;
        end
        emit = 1'b1;
      end
      PH_CSKIP: begin
        if (skip_left > 2'd0) skip_left = skip_left - 2'd1;
        if (skip_left == 2'd0) open_size_line();
      end
      default: ;
    endcase
    return emit;
  endfunction

  function automatic void predict_byte_item(logic bv, logic [7:0] b, logic se);
    result_t r;
    if (closed) return;
    if (bv) begin
      if (take_byte(b)) begin
        r = '0;
        r.result_kind = KIND_BODY;
        r.body_byte   = b;
        awaited_results.push_back(r);
      end
    end
    if (se) begin
      r = '0;
      r.result_kind = KIND_SUMMARY;
      r.status_code = status_val;
      r.response_ok = phase >= PH_PLAIN && status_sub != SUB_BEFORE;
      r.was_chunked = chunked;
      r.truncated   = phase == PH_CDATA && chunk_left != '0;
      r.last        = 1'b1;
      awaited_results.push_back(r);
      closed = 1'b1;
    end
  endfunction

  function automatic void report(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%s: expected kind=%0d byte=%02h status=%0d ok=%0b chunked=%0b trunc=%0b last=%0b",
               what, want.result_kind, want.body_byte, want.status_code, want.response_ok,
               want.was_chunked, want.truncated, want.last,
               " | got kind=%0d byte=%02h status=%0d ok=%0b chunked=%0b trunc=%0b last=%0b",
               got.result_kind, got.body_byte, got.status_code, got.response_ok,
               got.was_chunked, got.truncated, got.last);
  endfunction

  function automatic void check_result();
    result_t got;
    result_t want;
    got.result_kind = result_ch.result_kind;
    got.body_byte   = result_ch.body_byte;
    got.status_code = result_ch.status_code;
    got.response_ok = result_ch.response_ok;
    got.was_chunked = result_ch.was_chunked;
    got.truncated   = result_ch.truncated;
    got.last        = result_ch.last;
    if (awaited_results.size() == 0) begin
      report("unexpected result", '0, got);
      return;
    end
    want = awaited_results.pop_front();
    if (got !== want) report("result mismatch", want, got);
  endfunction

  // items in first, then results; a result never stems from the same edge
  always @(posedge clk) begin
    if (rst) begin
      clear_decoder();
      awaited_results.delete();
      mismatches = 0;
      awaited_count <= 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready)
        predict_byte_item(byte_ch.byte_valid, byte_ch.data_byte, byte_ch.stream_end);
      if (result_ch.valid && result_ch.ready) check_result();
      awaited_count <= awaited_results.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
// Drives one HTTP response through the chunk decoder: status line, headers,
// then a plain or chunked body with random content and a random ending.
module tb;
  import hrcd_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int BODY_TARGET  = 300;

  typedef enum int {
    MODE_NO_SPACE,
    MODE_NO_TERM,
    MODE_PLAIN,
    MODE_CHUNKED
  } response_mode_t;

  typedef enum int {
    END_ZERO_SIZE,
    END_EMPTY_SIZE,
    END_HUGE_CHUNK,
    END_SHORT_CHUNK,
    END_MID_FRAMING
  } chunk_end_t;

  logic        clk;
  logic        rst;
  int unsigned mismatches;
  int unsigned awaited_count;
  int unsigned idle_cycles;
  int          send_calm;
  int          sink_calm;
  int          body_bytes;

  hrcd_in_if  byte_ch();
  hrcd_out_if result_ch();

  http_response_chunk_decoder_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .byte_ch  (byte_ch),
    .result_ch(result_ch)
  );

  hrcd_result_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .byte_ch      (byte_ch),
    .result_ch    (result_ch),
    .mismatches   (mismatches),
    .awaited_count(awaited_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // mostly short gaps, a few long ones, now and then a calm stretch
  function automatic int idle_len(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm = $urandom_range(40, 120);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic put_item(input logic bv, input logic [7:0] b, input logic se);
    int gap;
    gap = idle_len(send_calm);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.byte_valid <= bv;
    byte_ch.data_byte  <= b;
    byte_ch.stream_end <= se;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
  endtask

  // a byte, sometimes preceded by an empty item
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 24) == 0) put_item(1'b0, 8'($urandom), 1'b0);
    put_item(1'b1, b, 1'b0);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // hold off until every awaited result is out
  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_body_byte(input logic [7:0] b);
    send_byte(b);
    body_bytes++;
    if (body_bytes == BODY_TARGET / 2) settle();
  endtask

  task automatic send_junk_line();
    logic [7:0] b;
    repeat ($urandom_range(1, 24)) begin
      b = 8'($urandom);
      if (b == CH_CR || b == CH_LF) b = "x";
      send_byte(b);
    end
  endtask

  // the chunked header, letters in random case
  task automatic send_te_header();
    logic [7:0] c;
    for (int i = 0; i < PAT_LEN; i++) begin
      c = TE_PATTERN[8*(PAT_LEN-1-i) +: 8];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
      send_byte(c);
    end
  endtask

  task automatic send_hex(input logic [63:0] v);
    int         msd;
    logic [3:0] nib;
    msd = 0;
    for (int i = 0; i < 16; i++) begin
      if (v[4*i +: 4] != 4'd0) msd = i;
    end
    for (int i = msd; i >= 0; i--) begin
      nib = v[4*i +: 4];
      if (nib < 4'd10) send_byte("0" + 8'(nib));
      else if ($urandom_range(0, 1) == 1) send_byte("A" + 8'(nib) - 8'd10);
      else send_byte("a" + 8'(nib) - 8'd10);
    end
  endtask

  // leading zeros, digits, optional extension, line end
  task automatic send_size_line(input logic [63:0] v);
    repeat ($urandom_range(0, 2)) send_byte("0");
    send_hex(v);
    case ($urandom_range(0, 5))
      0: send_text(";ext=1");
      1: send_text(" ;x");
      2: begin
        send_byte(CH_CR);
        send_text("z");
      end
      default: ;
    endcase
    send_crlf();
  endtask

  task automatic send_status_line(input response_mode_t mode);
    send_text("HTTP/1.1");
    if (mode == MODE_NO_SPACE) begin
      send_text("-200-OK");
    end else begin
      case ($urandom_range(0, 6))
        0: send_text(" 200 OK");
        1: begin
          send_text(" \t ");
          send_byte(CH_VT);
          send_byte(CH_FF);
          send_text("+404 Not Found");
        end
        2: send_text(" 99999 Big");
        3: send_text(" -17 Neg");
        4: send_text(" abc");
        5: send_text(" 30\n1\r2 Y");
        default: begin
          send_byte(CH_SP);
          send_text($sformatf("%0d", $urandom_range(100, 599)));
          send_text(" X");
        end
      endcase
    end
    send_crlf();
  endtask

  task automatic send_headers(input response_mode_t mode);
    logic with_te;
    with_te = (mode == MODE_CHUNKED) ||
              (mode != MODE_PLAIN && $urandom_range(0, 1) == 1);
    repeat (2) begin
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 3))
          0: send_text("Content-Type: text/plain");
          1: send_text("X-Trap: transfer-encoding: chunkex");
          2: send_text("Transfer-Encoding: identity");
          default: send_junk_line();
        endcase
        send_crlf();
      end
      if (with_te) begin
        if ($urandom_range(0, 1) == 1) send_text("t");
        send_te_header();
        send_crlf();
        with_te = 1'b0;
      end
    end
  endtask

  task automatic send_chunks();
    int roll;
    int size;
    while (body_bytes < BODY_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) size = $urandom_range(1, 16);
      else if (roll < 95) size = $urandom_range(17, 64);
      else size = $urandom_range(65, 160);
      send_size_line(64'(size));
      repeat (size) send_body_byte(8'($urandom));
      if ($urandom_range(0, 9) != 0) begin
        send_crlf();
      end else begin
        send_byte(8'($urandom));
        send_byte(8'($urandom));
      end
    end
  endtask

  // how a chunked body ends, with the closing item
  task automatic finish_chunks();
    logic [63:0] huge;
    int          size;
    case (chunk_end_t'($urandom_range(0, 4)))
      END_ZERO_SIZE: begin
        send_size_line(64'd0);
        if ($urandom_range(0, 1) == 1) begin
          send_text("X-Tail: 1");
          send_crlf();
        end
        send_crlf();
        repeat ($urandom_range(0, 8)) send_byte(8'($urandom));
        put_item(1'($urandom_range(0, 1)), 8'($urandom), 1'b1);
      end
      END_EMPTY_SIZE: begin
        if ($urandom_range(0, 1) == 1) send_text("zz");
        send_crlf();
        repeat ($urandom_range(0, 8)) send_byte(8'($urandom));
        put_item(1'($urandom_range(0, 1)), 8'($urandom), 1'b1);
      end
      END_HUGE_CHUNK: begin
        huge = {$urandom, $urandom};
        huge[63] = 1'b1;
        send_size_line(huge);
        repeat ($urandom_range(5, 30)) send_byte(8'($urandom));
        put_item(1'b1, 8'($urandom), 1'b1);
      end
      END_SHORT_CHUNK: begin
        size = $urandom_range(20, 60);
        send_size_line(64'(size));
        repeat ($urandom_range(0, size - 1)) send_byte(8'($urandom));
        put_item(1'b1, 8'($urandom), 1'b1);
      end
      default: begin
        send_text("1a");
        put_item(1'b0, 8'($urandom), 1'b1);
      end
    endcase
  endtask

  // result side: ready runs broken by stalls
  initial begin : sink_ctl
    int stall;
    sink_calm = 0;
    forever begin
      result_ch.ready <= 1'b1;
      if ($urandom_range(0, 29) == 0) repeat ($urandom_range(100, 300)) @(posedge clk);
      else repeat ($urandom_range(1, 30)) @(posedge clk);
      stall = idle_len(sink_calm);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // no item moved on either side for too long
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    response_mode_t mode;
    int             roll;
    logic [7:0]     b;
    rst                <= 1'b1;
    byte_ch.valid      <= 1'b0;
    byte_ch.byte_valid <= 1'b0;
    byte_ch.data_byte  <= 8'd0;
    byte_ch.stream_end <= 1'b0;
    send_calm  = 0;
    body_bytes = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    roll = $urandom_range(0, 19);
    if (roll == 0) mode = MODE_NO_SPACE;
    else if (roll == 1) mode = MODE_NO_TERM;
    else if (roll < 7) mode = MODE_PLAIN;
    else mode = MODE_CHUNKED;

    send_status_line(mode);
    send_headers(mode);
    if (mode != MODE_NO_TERM) send_crlf();
    settle();

    case (mode)
      MODE_CHUNKED: begin
        send_chunks();
        finish_chunks();
      end
      MODE_NO_TERM: begin
        // never a CR, so the blank line can not appear
        while (body_bytes < BODY_TARGET) begin
          b = 8'($urandom);
          if (b == CH_CR) b = "x";
          send_body_byte(b);
        end
        put_item(1'($urandom_range(0, 1)), 8'($urandom), 1'b1);
      end
      default: begin
        while (body_bytes < BODY_TARGET) send_body_byte(8'($urandom));
        put_item(1'($urandom_range(0, 1)), 8'($urandom), 1'b1);
      end
    endcase

    // the block stays silent after the summary
    repeat (3) put_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
    byte_ch.valid <= 1'b0;

    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/hrcd_pkg.sv
rtl/hrcd_ifs.sv
rtl/hrcd_parser.sv
rtl/hrcd_result_fifo.sv
rtl/http_response_chunk_decoder_unit.sv
tb/sv/hrcd_result_checker.sv
tb/sv/tb.sv
